// ===== design/bts_pkg.sv =====
`default_nettype none

package bts_pkg;

    localparam int CAPTURE_LIMIT = 31;
    localparam int MAX_DIGITS    = 18;
    localparam int CAP_W         = $clog2(CAPTURE_LIMIT + 1);
    localparam int TOKEN_COUNT   = 24;
    localparam int FRACTION_MAX  = 30;
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

    localparam logic [TOKEN_COUNT-1:0] MASK_ALL = '1;

    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_UP_A   = 8'h41;
    localparam logic [7:0] CHR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHR_LO_A   = 8'h61;
    localparam logic [7:0] CHR_LO_Z   = 8'h7A;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_PCT    = 8'h25;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_EQ     = 8'h3D;
    localparam logic [7:0] CHR_LT     = 8'h3C;
    localparam logic [7:0] CHR_GT     = 8'h3E;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_NL     = 8'h0A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [4:0] {
        LEX_NONE, LEX_NUMBER, LEX_PLUS, LEX_MINUS, LEX_MUL, LEX_MOD, LEX_DIV,
        LEX_EQUALS, LEX_VAR, LEX_PRINT, LEX_RUN, LEX_GOTO, LEX_IF, LEX_THEN,
        LEX_LT, LEX_GT, LEX_COMMA, LEX_GOSUB, LEX_LIST, LEX_RETURN, LEX_END,
        LEX_STRING, LEX_EOL, LEX_EOF
    } t_token;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_NUMBER, MODE_ALPHA, MODE_KEYWORD, MODE_STRING
    } t_mode;

    // token names right-aligned in 48 bits, highest code first
    localparam logic [TOKEN_COUNT-1:0][47:0] NAME_TABLE = {
        48'("EOF"), 48'("EOL"), 48'("STRING"), 48'("END"), 48'("RETURN"),
        48'("LIST"), 48'("GOSUB"), 48'("COMMA"), 48'("GT"), 48'("LT"),
        48'("THEN"), 48'("IF"), 48'("GOTO"), 48'("RUN"), 48'("PRINT"),
        48'("VAR"), 48'("EQUALS"), 48'("DIV"), 48'("MOD"), 48'("MUL"),
        48'("MINUS"), 48'("PLUS"), 48'("NUMBER"), 48'("NONE")
    };

    localparam logic [TOKEN_COUNT-1:0][2:0] NAME_LEN = {
        3'd3, 3'd3, 3'd6, 3'd3, 3'd6, 3'd4, 3'd5, 3'd5, 3'd2, 3'd2, 3'd4, 3'd2,
        3'd4, 3'd3, 3'd5, 3'd3, 3'd6, 3'd3, 3'd3, 3'd3, 3'd5, 3'd4, 3'd6, 3'd4
    };

    function automatic logic [59:0] f_mant_limit();
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < MAX_DIGITS && i < 19; i++) begin
            v = v * 64'd10;
        end
        v = v - 64'd1;
        if (v > 64'h0FFF_FFFF_FFFF_FFFF) begin
            v = 64'h0FFF_FFFF_FFFF_FFFF;
        end
        return v[59:0];
    endfunction

    localparam logic [59:0] MANT_LIMIT = f_mant_limit();

    typedef struct packed {
        t_token      token_code;
        logic        is_text_byte;
        logic [7:0]  text_byte;
        logic [4:0]  string_length;
        logic [59:0] mantissa;
        logic [4:0]  fraction_digits;
        logic        number_overflow;
        logic [4:0]  variable_index;
        logic        unknown_keyword;
        logic        last_result;
    } t_result;

    // results of one scan step, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // drop every name that does not have letter u at position pos
    function automatic logic [TOKEN_COUNT-1:0] f_narrow(
        logic [TOKEN_COUNT-1:0] mask,
        logic [CAP_W-1:0]       pos,
        logic [7:0]             u
    );
        logic [TOKEN_COUNT-1:0] m;
        int len;
        int p;
        m = mask;
        p = int'(pos);
        for (int i = 0; i < TOKEN_COUNT; i++) begin
            len = int'(NAME_LEN[i]);
            if (p >= len) begin
                m[i] = 1'b0;
            end else if (NAME_TABLE[i][(len - 1 - p) * 8 +: 8] != u) begin
                m[i] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic t_token f_op_code(logic [7:0] c);
        t_token t;
        case (c)
            CHR_PLUS:  t = LEX_PLUS;
            CHR_MINUS: t = LEX_MINUS;
            CHR_STAR:  t = LEX_MUL;
            CHR_PCT:   t = LEX_MOD;
            CHR_SLASH: t = LEX_DIV;
            CHR_EQ:    t = LEX_EQUALS;
            CHR_LT:    t = LEX_LT;
            CHR_GT:    t = LEX_GT;
            CHR_COMMA: t = LEX_COMMA;
            CHR_NL:    t = LEX_EOL;
            default:   t = LEX_NONE;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== design/bts_ifs.sv =====
`default_nettype none

interface bts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, char_in, end_of_input, input ready);
    modport sink   (input valid, char_in, end_of_input, output ready);
endinterface

interface bts_tok_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_code;
    logic        is_text_byte;
    logic [7:0]  text_byte;
    logic [4:0]  string_length;
    logic [59:0] mantissa;
    logic [4:0]  fraction_digits;
    logic        number_overflow;
    logic [4:0]  variable_index;
    logic        unknown_keyword;
    logic        last_result;

    modport source (
        output valid, token_code, is_text_byte, text_byte, string_length, mantissa,
               fraction_digits, number_overflow, variable_index, unknown_keyword,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, token_code, is_text_byte, text_byte, string_length, mantissa,
               fraction_digits, number_overflow, variable_index, unknown_keyword,
               last_result,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/bts_core.sv =====
`default_nettype none

module bts_core
    import bts_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  wire  [7:0] i_char,
    input  wire        i_eof,
    output t_push      o_push,
    output logic       o_halted
);

    t_mode                  r_mode, n_mode;
    logic [TOKEN_COUNT-1:0] r_mask, n_mask;
    logic [CAP_W-1:0]       r_cap, n_cap;
    logic [59:0]            r_digits, n_digits;
    logic [4:0]             r_frac, n_frac;
    logic [1:0]             r_dot, n_dot;
    logic                   r_ovf, n_ovf;
    logic [4:0]             r_first, n_first;
    logic                   r_halted, n_halted;

    logic        is_dig, is_alp, is_lower, cap_room, fits;
    logic [7:0]  up;
    logic [3:0]  dval;
    logic [63:0] dig_next;
    logic        kw_found;
    t_token      kw_code;
    logic        has_a, has_b, again;
    t_result     res_a, res_b, num_res, var_res;
    t_token      op;

    // character classes and the multiply by ten
    always_comb begin
        is_dig   = i_char inside {[CHR_ZERO:CHR_NINE]};
        is_lower = i_char inside {[CHR_LO_A:CHR_LO_Z]};
        is_alp   = is_lower || (i_char inside {[CHR_UP_A:CHR_UP_Z]});
        up       = is_lower ? (i_char - CASE_DELTA) : i_char;
        dval     = i_char[3:0];
        dig_next = ({4'b0, r_digits} << 3) + ({4'b0, r_digits} << 1) + 64'(dval);
        fits     = dig_next <= 64'(MANT_LIMIT);
        cap_room = r_cap < CAP_W'(CAPTURE_LIMIT);
        op       = f_op_code(i_char);
    end

    // lowest matching code wins
    always_comb begin
        kw_found = 1'b0;
        kw_code  = LEX_NONE;
        for (int i = TOKEN_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i] && (CAP_W'(NAME_LEN[i]) == r_cap)) begin
                kw_found = 1'b1;
                kw_code  = t_token'(5'(i));
            end
        end
    end

    always_comb begin
        num_res                 = '0;
        num_res.token_code      = LEX_NUMBER;
        num_res.mantissa        = r_digits;
        num_res.fraction_digits = r_frac;
        num_res.number_overflow = r_ovf;
        var_res                 = '0;
        var_res.token_code      = LEX_VAR;
        var_res.variable_index  = r_first;
    end

    // results of one step, and whether the byte starts a new token
    always_comb begin
        has_a = 1'b0;
        has_b = 1'b0;
        res_a = '0;
        res_b = '0;
        again = 1'b0;

        if (i_step && !r_halted) begin
            if (i_eof) begin
                case (r_mode)
                    MODE_NUMBER: begin
                        has_a = 1'b1;
                        res_a = num_res;
                    end
                    MODE_ALPHA: begin
                        has_a = 1'b1;
                        res_a = var_res;
                    end
                    MODE_KEYWORD: begin
                        has_a = 1'b1;
                        if (kw_found) begin
                            res_a.token_code = kw_code;
                        end else begin
                            res_a.unknown_keyword = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!((r_mode == MODE_KEYWORD) && !kw_found)) begin
                    has_b            = 1'b1;
                    res_b.token_code = LEX_EOF;
                end
            end else begin
                case (r_mode)
                    MODE_NUMBER: begin
                        if (!(is_dig || (i_char == CHR_DOT))) begin
                            has_a = 1'b1;
                            res_a = num_res;
                            again = 1'b1;
                        end
                    end
                    MODE_ALPHA: begin
                        if (!is_alp) begin
                            has_a = 1'b1;
                            res_a = var_res;
                            again = 1'b1;
                        end
                    end
                    MODE_KEYWORD: begin
                        if (!is_alp) begin
                            has_a = 1'b1;
                            if (kw_found) begin
                                res_a.token_code = kw_code;
                                again            = 1'b1;
                            end else begin
                                res_a.unknown_keyword = 1'b1;
                            end
                        end
                    end
                    MODE_STRING: begin
                        if (i_char == CHR_QUOTE) begin
                            has_a               = 1'b1;
                            res_a.token_code    = LEX_STRING;
                            res_a.string_length = 5'(r_cap);
                        end else if (cap_room) begin
                            has_a              = 1'b1;
                            res_a.is_text_byte = 1'b1;
                            res_a.text_byte    = i_char;
                        end
                    end
                    default: begin
                        again = 1'b1;
                    end
                endcase

                // an operator byte that starts a token gives its own result
                if (again && (op != LEX_NONE)) begin
                    has_b            = 1'b1;
                    res_b.token_code = op;
                end
            end
        end
    end

    // next scanner state
    always_comb begin
        n_mode   = r_mode;
        n_mask   = r_mask;
        n_cap    = r_cap;
        n_digits = r_digits;
        n_frac   = r_frac;
        n_dot    = r_dot;
        n_ovf    = r_ovf;
        n_first  = r_first;
        n_halted = r_halted;

        if (i_step && !r_halted) begin
            if (i_eof) begin
                n_mode = MODE_IDLE;
                if ((r_mode == MODE_KEYWORD) && !kw_found) begin
                    n_halted = 1'b1;
                end
            end else begin
                case (r_mode)
                    MODE_NUMBER: begin
                        if ((is_dig || (i_char == CHR_DOT)) && cap_room) begin
                            n_cap = r_cap + 1'b1;
                            if (i_char == CHR_DOT) begin
                                if (r_dot < 2'd2) begin
                                    n_dot = r_dot + 1'b1;
                                end
                            end else if (r_dot == 2'd0) begin
                                if (!r_ovf) begin
                                    if (fits) begin
                                        n_digits = dig_next[59:0];
                                    end else begin
                                        n_digits = MANT_LIMIT;
                                        n_ovf    = 1'b1;
                                    end
                                end
                            end else if (r_dot == 2'd1) begin
                                // fraction digit
                                if (r_ovf || (r_frac >= 5'(FRACTION_MAX)) || !fits) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_digits = dig_next[59:0];
                                    n_frac   = r_frac + 1'b1;
                                end
                            end
                        end
                    end
                    MODE_ALPHA: begin
                        if (is_alp) begin
                            if (cap_room) begin
                                n_mask = f_narrow(r_mask, r_cap, up);
                                n_cap  = r_cap + 1'b1;
                            end
                            n_mode = MODE_KEYWORD;
                        end
                    end
                    MODE_KEYWORD: begin
                        if (is_alp) begin
                            if (cap_room) begin
                                n_mask = f_narrow(r_mask, r_cap, up);
                                n_cap  = r_cap + 1'b1;
                            end
                        end else if (!kw_found) begin
                            n_halted = 1'b1;
                            n_mode   = MODE_IDLE;
                        end
                    end
                    MODE_STRING: begin
                        if (i_char == CHR_QUOTE) begin
                            n_mode = MODE_IDLE;
                        end else if (cap_room) begin
                            n_cap = r_cap + 1'b1;
                        end
                    end
                    default: ;
                endcase

                // ending byte starts the next token
                if (again) begin
                    n_mode = MODE_IDLE;
                    if (is_dig) begin
                        n_cap    = CAP_W'(1);
                        n_digits = 60'(dval);
                        n_frac   = '0;
                        n_dot    = '0;
                        n_ovf    = 1'b0;
                        n_mode   = MODE_NUMBER;
                    end else if (is_alp) begin
                        n_mask  = f_narrow(MASK_ALL, '0, up);
                        n_cap   = CAP_W'(1);
                        n_first = 5'(up - CHR_UP_A);
                        n_mode  = MODE_ALPHA;
                    end else if (i_char == CHR_QUOTE) begin
                        n_cap  = '0;
                        n_mode = MODE_STRING;
                    end
                end
            end
        end
    end

    // pack the results and mark the last one
    always_comb begin
        o_push = '0;
        if (has_a && has_b) begin
            o_push.count              = 2'd2;
            o_push.first              = res_a;
            o_push.second             = res_b;
            o_push.second.last_result = 1'b1;
        end else if (has_a) begin
            o_push.count             = 2'd1;
            o_push.first             = res_a;
            o_push.first.last_result = 1'b1;
        end else if (has_b) begin
            o_push.count             = 2'd1;
            o_push.first             = res_b;
            o_push.first.last_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_mask   <= MASK_ALL;
            r_cap    <= '0;
            r_digits <= '0;
            r_frac   <= '0;
            r_dot    <= '0;
            r_ovf    <= 1'b0;
            r_first  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_mask   <= n_mask;
            r_cap    <= n_cap;
            r_digits <= n_digits;
            r_frac   <= n_frac;
            r_dot    <= n_dot;
            r_ovf    <= n_ovf;
            r_first  <= n_first;
            r_halted <= n_halted;
        end
    end

    assign o_halted = r_halted;

endmodule

`default_nettype wire

// ===== design/bts_res_fifo.sv =====
`default_nettype none

module bts_res_fifo
    import bts_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_push            i_push,
    output logic             o_room,
    bts_tok_if.source        o_tok
);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             pop;
    t_result          head;

    assign pop  = (r_cnt != '0) && o_tok.ready;
    assign head = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.count);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[PTR_W'(r_wr + 1'b1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // room for a full two-result step
    assign o_room = r_cnt <= CNT_W'(FIFO_DEPTH - 2);

    assign o_tok.valid           = r_cnt != '0;
    assign o_tok.token_code      = head.token_code;
    assign o_tok.is_text_byte    = head.is_text_byte;
    assign o_tok.text_byte       = head.text_byte;
    assign o_tok.string_length   = head.string_length;
    assign o_tok.mantissa        = head.mantissa;
    assign o_tok.fraction_digits = head.fraction_digits;
    assign o_tok.number_overflow = head.number_overflow;
    assign o_tok.variable_index  = head.variable_index;
    assign o_tok.unknown_keyword = head.unknown_keyword;
    assign o_tok.last_result     = head.last_result;

endmodule

`default_nettype wire

// ===== design/basic_token_scanner_top.sv =====
`default_nettype none

// BASIC token scanner: takes one source byte per beat on i_byte and gives
// tokens on o_tok (numbers as a saturating decimal mantissa plus a fraction
// digit count, single-letter variables, keywords matched without regard to
// case, operators, comma, end of line, end of file), and string contents one
// byte per beat followed by a string token. A byte that ends a number or word
// yields that token and then its own token, so one input beat gives zero, one
// or two result beats; last_result marks the final one. An input byte lands in
// the input register and is scanned once the result queue has room, and its
// results pass through the result queue to o_tok. The scanner keeps up to
// four results queued; it stalls input only while fewer than two slots are
// free, so steady throughput is one byte per cycle, and bytes that give two
// results are bounded by the one-beat-per-cycle output port. An unknown
// keyword gives one result with unknown_keyword set and the block then
// discards all input until reset.
module basic_token_scanner_top
    import bts_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    bts_byte_if.sink   i_byte,
    bts_tok_if.source  o_tok
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eof;

    logic  fifo_room;
    logic  step;
    logic  halted;
    t_push push;

    // scan the held byte once the result queue can take two beats
    assign step         = r_in_valid && fifo_room;
    assign i_byte.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_char <= i_byte.char_in;
            r_in_eof  <= i_byte.end_of_input;
        end
    end

    // scanner state and token decision
    bts_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_eof    (r_in_eof),
        .o_push   (push),
        .o_halted (halted)
    );

    // result queue toward the output port
    bts_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (fifo_room),
        .o_tok   (o_tok)
    );

`ifndef SYNTHESIS
    // results only come from a scanned beat
    a_push_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> step)
        else $error("results pushed without a scanned beat");

    // no results are pushed once halted
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        halted |-> (push.count == 2'd0))
        else $error("results pushed while halted");

    // only the second of a pair carries the last mark
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (!push.first.last_result && push.second.last_result))
        else $error("last mark misplaced on a result pair");

    // a held byte waits unchanged until scanned
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_eof)))
        else $error("held input byte lost or changed");
`endif

endmodule

`default_nettype wire
